@@ rtl/core/edf_pkg.sv @@
// edf_pkg: shared types and constants for the edf task scheduler
// no dependencies
package edf_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PERIOD = 2'd1,
    OP_DEMAND = 2'd2,
    OP_START  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_READY   = 2'd1,
    PH_RUNNING = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEMAND,
    ST_CHECK,
    ST_CREDIT,
    ST_FAIL,
    ST_WAKE,
    ST_PICK,
    ST_COMMIT,
    ST_EXEC,
    ST_START,
    ST_DONE
  } state_t;

  localparam logic [1:0] CFG_QUANTUM = 2'd0;
  localparam logic [1:0] CFG_HORIZON = 2'd1;
  localparam logic [1:0] CFG_TCOUNT  = 2'd2;

  localparam int unsigned CFG_WIDTH = 32;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  task_index;
    logic [3:0]  job_slot;
    logic [15:0] value;
    logic        high_crit;
  } in_item_t;

  typedef struct packed {
    logic        running_valid;
    logic [2:0]  running_task;
    logic [31:0] switch_count;
    logic [31:0] low_success;
    logic [31:0] high_success;
    logic [31:0] low_failed;
    logic [31:0] high_failed;
    logic [31:0] current_time;
  } out_item_t;

  // saturating counter increment
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [1:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {31'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

@@ rtl/core/edf_task_scheduler.sv @@
// edf_task_scheduler: tick-driven earliest-deadline-first scheduler
// uses edf_pkg; task tables in flip-flops, demand table as a memory
//
// One item is taken at a time. A set item and a tick past the horizon go
// straight to the result; a start item first resets every task slot. A
// tick that is not a decision checks for an event and then advances time.
// A decision tick walks the tasks, sharing one saturating time adder, in
// three passes (deadline check, wakeup, minimum search) at one task per
// cycle, then commits the choice and advances time. The result item is
// held until out_ready. The demand table is a memory with one write port
// and one read port and a registered read; unwritten entries read as
// anything. No clearing pass is needed.
module edf_task_scheduler #(
  parameter int MAX_TASKS  = 8,
  parameter int JOB_SLOTS  = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  edf_pkg::in_item_t      in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output edf_pkg::out_item_t     out_data,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [edf_pkg::CFG_WIDTH-1:0] cfg_wdata
);
  import edf_pkg::*;

  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int SW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int DEPTH = MAX_TASKS * JOB_SLOTS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [TIME_WIDTH-1:0] TMAX = {TIME_WIDTH{1'b1}};

  // job slot of a demand write, wrapped to the number of job slots
  function automatic logic [SW-1:0] slot_wrap(input logic [3:0] s);
    logic [4:0] v;
    v = {1'b0, s};
    for (int k = 0; k < 16; k++) begin
      if (JOB_SLOTS < 16 && int'(v) >= JOB_SLOTS) v = v - 5'(JOB_SLOTS);
    end
    return SW'(v);
  endfunction

  // next job number, wrapping at the number of job slots
  function automatic logic [SW-1:0] job_next(input logic [SW-1:0] j);
    return (j == SW'(JOB_SLOTS - 1)) ? '0 : j + 1'b1;
  endfunction

  // configuration
  logic [15:0] quantum_r;
  logic [31:0] horizon_r;
  logic [3:0]  tcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= 16'd1;
      horizon_r <= 32'hFFFF_FFFF;
      tcount_r  <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUANTUM: quantum_r <= cfg_wdata[15:0];
        CFG_HORIZON: horizon_r <= cfg_wdata[31:0];
        CFG_TCOUNT:  tcount_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // tasks in use, clamped to the table size
  logic [CW-1:0] n_used;
  always_comb begin
    if ({28'd0, tcount_r} > MAX_TASKS) n_used = CW'(MAX_TASKS);
    else n_used = CW'(tcount_r);
  end

  // task state
  logic [15:0]           period_r [MAX_TASKS];
  logic                  high_r   [MAX_TASKS];
  phase_t                phase_r  [MAX_TASKS];
  logic [15:0]           exec_r   [MAX_TASKS];
  logic [TIME_WIDTH-1:0] dl_r     [MAX_TASKS];
  logic [TIME_WIDTH-1:0] wk_r     [MAX_TASKS];
  logic [SW-1:0]         job_r    [MAX_TASKS];

  logic                  run_v_r;
  logic [TW-1:0]         run_t_r;
  logic [TIME_WIDTH-1:0] time_r;
  logic [15:0]           qcnt_r;
  logic [31:0]           sw_r, lok_r, hok_r, lfl_r, hfl_r;
  logic                  done_r;

  // sequencer state
  state_t        st_r, st_nxt;
  in_item_t      item_r;
  logic [CW-1:0] idx_r;
  logic          best_v_r;
  logic [TW-1:0] best_r;
  logic [TIME_WIDTH-1:0] best_dl_r;
  logic          decide_r;
  logic          out_v_r;

  // demand memory
  logic [15:0] dem_mem [DEPTH];
  logic [15:0] dem_q_r;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [TW-1:0] wr_task;
  assign wr_task = TW'(item_r.task_index);
  assign wr_addr = AW'(wr_task * JOB_SLOTS + slot_wrap(item_r.job_slot));
  assign rd_addr = AW'(run_t_r * JOB_SLOTS + job_r[run_t_r]);

  always_ff @(posedge clk) begin
    if (st_r == ST_DEMAND && item_r.op == OP_DEMAND &&
        {29'd0, item_r.task_index} < MAX_TASKS)
      dem_mem[wr_addr] <= item_r.value;
    dem_q_r <= dem_mem[rd_addr];
  end

  // shared time unit: saturating add
  logic [TIME_WIDTH-1:0] ua, ub, usum;
  logic [TIME_WIDTH:0]   uraw;
  logic [TW-1:0]         it;
  assign it   = TW'(idx_r);
  assign uraw = {1'b0, ua} + {1'b0, ub};
  assign usum = uraw[TIME_WIDTH] ? TMAX : uraw[TIME_WIDTH-1:0];

  always_comb begin
    ua = wk_r[it];
    ub = TIME_WIDTH'(period_r[it]);
    if (st_r == ST_START) begin
      ua = '0;
    end
  end

  // wakeup plus period for the running task at credit time
  logic [TIME_WIDTH-1:0] usum_run;
  logic [TIME_WIDTH:0]   uraw_run;
  assign uraw_run = {1'b0, wk_r[run_t_r]} + {1'b0, TIME_WIDTH'(period_r[run_t_r])};
  assign usum_run = uraw_run[TIME_WIDTH] ? TMAX : uraw_run[TIME_WIDTH-1:0];

  // a start pass after reset gives no item; one from an input item does
  logic is_start_item_r;
  always_ff @(posedge clk) begin
    if (!rst_n) is_start_item_r <= 1'b0;
    else if (st_r == ST_IDLE && in_valid) is_start_item_r <= 1'b1;
  end

  logic last_idx;
  assign last_idx = (idx_r + 1'b1 >= n_used);
  logic t_in_range;
  assign t_in_range = ((TIME_WIDTH+32)'(time_r) <= (TIME_WIDTH+32)'(horizon_r));

  // decision due: quantum boundary, or running job finished or late
  logic decide_now;
  logic dem_met;
  assign dem_met = (exec_r[run_t_r] >= dem_q_r);
  assign decide_now = decide_r || (run_v_r && (dem_met || time_r > dl_r[run_t_r]));

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_valid) begin
        case (in_data.op)
          OP_TICK:  st_nxt = ST_DEMAND;
          OP_START: st_nxt = ST_START;
          default:  st_nxt = ST_DEMAND;
        endcase
      end
      ST_DEMAND: begin
        if (item_r.op != OP_TICK) st_nxt = ST_DONE;
        else if (done_r || !t_in_range) st_nxt = ST_DONE;
        else st_nxt = ST_CHECK;
      end
      ST_CHECK:  st_nxt = decide_now ? ST_CREDIT : ST_EXEC;
      ST_CREDIT: st_nxt = (n_used == 0) ? ST_PICK : ST_FAIL;
      ST_FAIL:   if (last_idx) st_nxt = ST_WAKE;
      ST_WAKE:   if (last_idx) st_nxt = ST_PICK;
      ST_PICK:   if (last_idx || n_used == 0) st_nxt = ST_COMMIT;
      ST_COMMIT: st_nxt = ST_EXEC;
      ST_EXEC:   st_nxt = ST_DONE;
      ST_START:  if (idx_r == CW'(MAX_TASKS - 1)) st_nxt = ST_DONE;
      ST_DONE:   if (out_ready || !out_v_r) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_START;
    else st_r <= st_nxt;
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = (st_r == ST_IDLE);
    out_valid = out_v_r;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      idx_r   <= '0;
      run_v_r <= 1'b0;
      done_r  <= 1'b0;
      time_r  <= '0;
      qcnt_r  <= '0;
      sw_r <= '0; lok_r <= '0; hok_r <= '0; lfl_r <= '0; hfl_r <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        period_r[i] <= '0;
        high_r[i]   <= 1'b0;
      end
    end else begin
      case (st_r)
        ST_IDLE: begin
          item_r <= in_data;
          idx_r  <= '0;
        end
        ST_DEMAND: begin
          if (item_r.op == OP_PERIOD && {29'd0, item_r.task_index} < MAX_TASKS) begin
            period_r[wr_task] <= item_r.value;
            high_r[wr_task]   <= item_r.high_crit;
          end
          if (item_r.op != OP_TICK) out_v_r <= 1'b1;
          else if (done_r || !t_in_range) out_v_r <= 1'b1;
          else begin
            // quantum countdown and event check (demand read now valid)
            if (qcnt_r == 16'd0) qcnt_r <= (quantum_r == 16'd0) ? 16'd0 : quantum_r - 16'd1;
            else qcnt_r <= qcnt_r - 16'd1;
            decide_r <= (qcnt_r == 16'd0);
          end
        end
        ST_CHECK: begin
          decide_r <= decide_now;
          if (decide_now) begin
            sw_r <= sat_add(sw_r, 2'd2);
            // running task no longer in use
            if (run_v_r && {1'b0, run_t_r} >= (TW+1)'(n_used)) begin
              phase_r[run_t_r] <= PH_READY;
              run_v_r <= 1'b0;
            end
          end
        end
        ST_CREDIT: begin
          idx_r <= '0;
          best_v_r <= 1'b0;
          if (run_v_r && dem_met) begin
            if (high_r[run_t_r]) hok_r <= sat_add(hok_r, 2'd1);
            else lok_r <= sat_add(lok_r, 2'd1);
            job_r[run_t_r]   <= job_next(job_r[run_t_r]);
            phase_r[run_t_r] <= PH_IDLE;
            wk_r[run_t_r]    <= usum_run;
            exec_r[run_t_r]  <= '0;
            run_v_r <= 1'b0;
          end
        end
        ST_FAIL: begin
          idx_r <= last_idx ? '0 : idx_r + 1'b1;
          if ((phase_r[it] == PH_READY || phase_r[it] == PH_RUNNING) && time_r > dl_r[it]) begin
            job_r[it]   <= job_next(job_r[it]);
            phase_r[it] <= PH_IDLE;
            wk_r[it]    <= usum;
            exec_r[it]  <= '0;
            if (high_r[it]) hfl_r <= sat_add(hfl_r, 2'd1);
            else lfl_r <= sat_add(lfl_r, 2'd1);
            if (run_v_r && run_t_r == it) run_v_r <= 1'b0;
          end
        end
        ST_WAKE: begin
          idx_r <= last_idx ? '0 : idx_r + 1'b1;
          if (phase_r[it] == PH_IDLE && time_r >= wk_r[it]) begin
            phase_r[it] <= PH_READY;
            dl_r[it]    <= usum;
          end
          best_v_r  <= run_v_r;
          best_r    <= run_t_r;
          best_dl_r <= dl_r[run_t_r];
        end
        ST_PICK: begin
          idx_r <= last_idx ? '0 : idx_r + 1'b1;
          if (n_used != 0 && phase_r[it] == PH_READY &&
              (!best_v_r || dl_r[it] < best_dl_r)) begin
            best_v_r  <= 1'b1;
            best_r    <= it;
            best_dl_r <= dl_r[it];
          end
        end
        ST_COMMIT: begin
          if (best_v_r && (!run_v_r || best_r != run_t_r)) begin
            if (run_v_r) phase_r[run_t_r] <= PH_READY;
            phase_r[best_r] <= PH_RUNNING;
          end
          run_v_r <= best_v_r;
          run_t_r <= best_r;
        end
        ST_EXEC: begin
          if (run_v_r && exec_r[run_t_r] != 16'hFFFF)
            exec_r[run_t_r] <= exec_r[run_t_r] + 16'd1;
          if (time_r == TMAX) done_r <= 1'b1;
          else time_r <= time_r + 1'b1;
          out_v_r <= 1'b1;
        end
        ST_START: begin
          phase_r[it] <= PH_READY;
          exec_r[it]  <= '0;
          wk_r[it]    <= '0;
          dl_r[it]    <= usum;
          job_r[it]   <= '0;
          idx_r <= idx_r + 1'b1;
          if (idx_r == CW'(MAX_TASKS - 1)) begin
            sw_r <= '0; lok_r <= '0; hok_r <= '0; lfl_r <= '0; hfl_r <= '0;
            time_r <= '0; qcnt_r <= '0; run_v_r <= 1'b0; done_r <= 1'b0;
            out_v_r <= (item_r.op == OP_START) && is_start_item_r;
          end
        end
        ST_DONE: if (out_ready) out_v_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // result item
  always_comb begin
    out_data.running_valid = run_v_r;
    out_data.running_task  = run_v_r ? 3'(run_t_r) : 3'd0;
    out_data.switch_count  = sw_r;
    out_data.low_success   = lok_r;
    out_data.high_success  = hok_r;
    out_data.low_failed    = lfl_r;
    out_data.high_failed   = hfl_r;
    out_data.current_time  = 32'(time_r);
  end

  // assertions
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_run_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && run_v_r) |-> phase_r[run_t_r] == PH_RUNNING)
    else $error("running task not in running phase");

endmodule
